[hw/rtl/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types and constants for the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

    // width of every payload port
    localparam int FIELD_W = 32;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REDUCE = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_SQR    = 6'b010000,
        ST_FIN    = 6'b100000
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture a new word, start base reduction
        logic mul_init;  // clear product, load multiplier operands
        logic sqr_sel;   // with mul_init: multiplicand is run instead of acc
        logic step;      // one bit step of the shared unit
        logic reduce;    // with step: restoring remainder instead of mod-mul
        logic acc_wr;    // accumulator takes the step result
        logic run_wr;    // running power takes the step result
        logic exp_shift; // drop the exponent lsb
        logic out_load;  // output register takes the accumulator
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic exp_zero;  // exponent fully consumed
        logic exp_lsb;   // current exponent bit
        logic exp_last;  // only the lsb may still be set
    } dp_status_t;

endpackage

[hw/rtl/mexp_dp.sv]
// ----------------------------------------------------------------------------
// mexp_dp
// operand registers and the shared bit-serial modular multiply / reduce unit
// ----------------------------------------------------------------------------
module mexp_dp #(
    parameter int WIDTH = 32
) (
    input  logic                         clk,
    input  mexp_pkg::ctrl_cmd_t          cmd,
    output mexp_pkg::dp_status_t         status,
    input  logic [mexp_pkg::FIELD_W-1:0] base_value,
    input  logic [mexp_pkg::FIELD_W-1:0] exponent_value,
    input  logic [mexp_pkg::FIELD_W-1:0] modulus_value,
    output logic [mexp_pkg::FIELD_W-1:0] power_residue
);
    import mexp_pkg::*;

    logic [WIDTH-1:0] base_w;
    logic [WIDTH-1:0] exp_w;
    logic [WIDTH-1:0] mod_w;

    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] run_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH:0]   mod_reg;   // zero modulus held as 2^WIDTH
    logic [WIDTH-1:0] p_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] out_reg;

    logic [WIDTH:0]   red_sum;
    logic [WIDTH:0]   red_res;
    logic [WIDTH-1:0] dbl_val;
    logic [WIDTH-1:0] mul_val;
    logic [WIDTH-1:0] p_next;

    // (x + y) mod m for x, y below m
    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic [WIDTH:0]   m
    );
        logic [WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= m)
        begin
            s = s - m;
        end
        return s[WIDTH-1:0];
    endfunction

    assign base_w = WIDTH'(base_value);
    assign exp_w  = WIDTH'(exponent_value);
    assign mod_w  = WIDTH'(modulus_value);

    // restoring remainder step, base bits enter msb first
    assign red_sum = {p_reg, b_reg[WIDTH-1]};
    assign red_res = (red_sum >= mod_reg) ? (red_sum - mod_reg) : red_sum;

    // double-and-add step, multiplier bits msb first
    assign dbl_val = add_mod(p_reg, p_reg, mod_reg);
    assign mul_val = b_reg[WIDTH-1] ? add_mod(dbl_val, a_reg, mod_reg) : dbl_val;

    assign p_next = cmd.reduce ? red_res[WIDTH-1:0] : mul_val;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            exp_reg <= exp_w;
            mod_reg <= (mod_w == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, mod_w};
            acc_reg <= ((mod_w == {{(WIDTH-1){1'b0}}, 1'b1}) && (exp_w != '0))
                       ? '0 : {{(WIDTH-1){1'b0}}, 1'b1};
            p_reg   <= '0;
            b_reg   <= base_w;
        end
        else if (cmd.mul_init)
        begin
            p_reg <= '0;
            a_reg <= cmd.sqr_sel ? run_reg : acc_reg;
            b_reg <= run_reg;
        end
        else if (cmd.step)
        begin
            p_reg <= p_next;
            b_reg <= {b_reg[WIDTH-2:0], 1'b0};
        end

        if (cmd.acc_wr)
        begin
            acc_reg <= p_next;
        end
        if (cmd.run_wr)
        begin
            run_reg <= p_next;
        end
        if (cmd.exp_shift)
        begin
            exp_reg <= {1'b0, exp_reg[WIDTH-1:1]};
        end
        if (cmd.out_load)
        begin
            out_reg <= acc_reg;
        end
    end

    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.exp_last = (exp_reg[WIDTH-1:1] == '0);

    assign power_residue = FIELD_W'(out_reg);

endmodule

[hw/rtl/mexp_ctrl.sv]
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer: steps the shared unit through reduction, multiplies and squares
// ----------------------------------------------------------------------------
module mexp_ctrl #(
    parameter int WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  mexp_pkg::dp_status_t status,
    output mexp_pkg::ctrl_cmd_t  cmd
);
    import mexp_pkg::*;

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] CNT_TOP = CW'(WIDTH - 1);

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            cnt_last;

    assign cnt_last  = (cnt_reg == '0);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_TOP;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.step   = 1'b1;
                cmd.reduce = 1'b1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_last)
                begin
                    cmd.run_wr = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.exp_zero)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.mul_init = 1'b1;
                    cmd.sqr_sel  = !status.exp_lsb;
                    cnt_next     = CNT_TOP;
                    state_next   = status.exp_lsb ? ST_MUL : ST_SQR;
                end
            end
            ST_MUL:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_last)
                begin
                    cmd.acc_wr = 1'b1;
                    if (status.exp_last)
                    begin
                        // last set bit: the final square is never used
                        cmd.exp_shift = 1'b1;
                        state_next    = ST_FIN;
                    end
                    else
                    begin
                        cmd.mul_init = 1'b1;
                        cmd.sqr_sel  = 1'b1;
                        cnt_next     = CNT_TOP;
                        state_next   = ST_SQR;
                    end
                end
            end
            ST_SQR:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_last)
                begin
                    cmd.run_wr    = 1'b1;
                    cmd.exp_shift = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ^ exponent mod modulus, right-to-left binary scan of the exponent
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | base_value, exponent_value, modulus_value
//  out     | out_valid / out_ready| power_residue
//
//  one word in, one word out; a new input word is taken only in the idle
//  state; the word is loaded, the base reduced, then per exponent bit up
//  to the top set bit come a scan step, a multiply when the bit is set
//  and a square (the top square is skipped), then the output is loaded;
//  all steps use the single shared bit-serial multiply/reduce unit,
//  one multiplier bit per cycle
//  reset clears the sequencer and the output valid; no clearing pass
//  a stalled output only holds the finished word; the next input word is
//  taken meanwhile and is held in the final state until the output frees
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mexp_pkg::FIELD_W-1:0] base_value,
    input  logic [mexp_pkg::FIELD_W-1:0] exponent_value,
    input  logic [mexp_pkg::FIELD_W-1:0] modulus_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mexp_pkg::FIELD_W-1:0] power_residue
);
    import mexp_pkg::*;

    // command and status between sequencer and datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: state, bit counter, output valid
    mexp_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: acc, running power, exponent shifter, shared mod-mul unit
    // a zero modulus is kept as 2^WIDTH so products simply wrap
    mexp_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk            (clk),
        .cmd            (cmd),
        .status         (status),
        .base_value     (base_value),
        .exponent_value (exponent_value),
        .modulus_value  (modulus_value),
        .power_residue  (power_residue)
    );

endmodule

[hw/rtl/mexp_checker.sv]
// ----------------------------------------------------------------------------
// mexp_checker
// port-level checks on the modular exponentiation block
// ----------------------------------------------------------------------------
module mexp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [mexp_pkg::FIELD_W-1:0] power_residue
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_residue))
        else $error("output word changed while stalled");

    // busy at the start of the base reduction after an accepted word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input taken again during reduction");

    // a result only follows a busy cycle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

[tb/sv/tb_modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// self-checking bench: every accepted word is predicted as
// base ^ exponent mod modulus, and each output word is compared in order;
// directed corner words first, then random words under varied idling
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = mexp_pkg::FIELD_W;

    // limit on quiet cycles, well above the longest word
    localparam int STALL_LIMIT = 20000;
    // every word yields a result, so little is left in flight at the end
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_PER_PHASE = 68;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    logic [W-1:0] base_value;
    logic [W-1:0] exponent_value;
    logic [W-1:0] modulus_value;
    logic         out_valid;
    logic         out_ready;
    logic [W-1:0] power_residue;

    // idle and stall odds in percent, changed per phase
    int unsigned  send_idle_pct;
    int unsigned  sink_stall_pct;
    int unsigned  quiet_cycles;

    // ------------------------------------------------------------------------
    // expected residues, oldest first
    // ------------------------------------------------------------------------
    class residue_scoreboard;
        logic [W-1:0] residue_q[$];
        int           mismatches;

        function new();
            mismatches = 0;
        endfunction

        // right-to-left binary exponentiation; products fit in 64 bits
        static function logic [W-1:0] predict_residue(logic [W-1:0] b,
                                                      logic [W-1:0] e,
                                                      logic [W-1:0] m);
            logic [63:0]  acc;
            logic [63:0]  run;
            logic [63:0]  modw;
            logic [W-1:0] bits;
            modw = {32'd0, m};
            run  = {32'd0, b} % modw;
            acc  = 64'd1;
            bits = e;
            while (bits != '0)
            begin
                if (bits[0])
                    acc = (acc * run) % modw;
                bits = bits >> 1;
                run  = (run * run) % modw;
            end
            return acc[W-1:0];
        endfunction

        function void note_input(logic [W-1:0] b, logic [W-1:0] e,
                                 logic [W-1:0] m);
            residue_q.push_back(predict_residue(b, e, m));
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [W-1:0] got);
            logic [W-1:0] want;
            if (residue_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word power_residue=%h", got));
            end
            else
            begin
                want = residue_q.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("power_residue got %h want %h",
                                              got, want));
            end
        endtask

        function int pending();
            return residue_q.size();
        endfunction
    endclass

    residue_scoreboard sb;

    modular_exponentiation #(
        .WIDTH(W)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .base_value     (base_value),
        .exponent_value (exponent_value),
        .modulus_value  (modulus_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .power_residue  (power_residue)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // input side: one word per call, one assignment per falling edge
    // ------------------------------------------------------------------------
    task send_word(logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
        // random idle cycles before the word; valid drops during the gap
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        base_value     <= b;
        exponent_value <= e;
        modulus_value  <= m;
        in_valid       <= 1'b1;
        // hold until the block takes the word
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(b, e, m);
    endtask

    task send_random_word();
        logic [W-1:0] b;
        logic [W-1:0] e;
        logic [W-1:0] m;
        case ($urandom_range(3))
            0, 1:    m = $urandom();
            2:       m = $urandom_range(1000, 1);
            default: m = $urandom() >> $urandom_range(31);
        endcase
        if (m == '0)
            m = $urandom_range(32'hFFFF_FFFF, 1);
        case ($urandom_range(3))
            0, 1:    b = $urandom();
            2:       b = $urandom_range(16);
            default: b = m + W'($urandom_range(2)) - W'(1); // around the modulus
        endcase
        // mostly short exponents keep the run length down
        case ($urandom_range(9))
            0, 1, 2, 3: e = $urandom();
            4, 5, 6:    e = $urandom() >> $urandom_range(31, 16);
            7, 8:       e = $urandom_range(20);
            default:    e = W'(1) << $urandom_range(31);
        endcase
        send_word(b, e, m);
    endtask

    // ------------------------------------------------------------------------
    // output side: random backpressure, changed on falling edges
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // compare every accepted output word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(power_residue);
    end

    // watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        in_valid       = 1'b0;
        base_value     = '0;
        exponent_value = '0;
        modulus_value  = '1;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        sb = new();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words, no idling
        send_word(32'h0000_0003, 32'h0000_0000, 32'h0000_0001); // zero exponent, modulus one
        send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0001); // zero to the zero, modulus one
        send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0007); // zero to the zero
        send_word(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF); // zero exponent, max operands
        send_word(32'h0000_3039, 32'h0000_004D, 32'h0000_0001); // modulus one, nonzero exponent
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001); // modulus one, max exponent
        send_word(32'h0000_0000, 32'h0000_0005, 32'h0000_000D); // zero base
        send_word(32'h0000_0004, 32'h0000_000D, 32'h0000_01F1); // small textbook case
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // all ones
        send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // base is modulus minus one
        send_word(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_000A); // base needs reduction
        send_word(32'h0000_0007, 32'h0000_0001, 32'h0000_000B); // exponent one
        send_word(32'hFFFF_FFFB, 32'h8000_0000, 32'hFFFF_FFFF); // only the top exponent bit
        send_word(32'h0000_0003, 32'h8000_0000, 32'h8000_0000); // power-of-two modulus
        send_word(32'h1234_5678, 32'h0000_0002, 32'h1234_5678); // base equals modulus
        send_word(32'h0000_0002, 32'h0000_001F, 32'h0000_0002); // modulus two
        send_word(32'hDEAD_BEEF, 32'h5555_5555, 32'hFFFF_FFFB); // largest 32-bit prime
        send_word(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555); // alternating bits
        send_word(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003); // base one
        send_word(32'h0000_0002, 32'h0000_0020, 32'hFFFF_FFFF); // two to the width

        // random words under each idling mix
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 87;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 87;
                end
                default:
                begin
                    send_idle_pct  = 30;
                    sink_stall_pct = 30;
                end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                send_random_word();
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // drain, then watch for stray words
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected words never arrived",
                                         sb.pending()));
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
